>>> sv/tsmt_pkg.sv
package tsmt_pkg;

  localparam int INPUT_COUNT  = 784;
  localparam int HIDDEN_COUNT = 256;
  localparam int OUTPUT_COUNT = 10;
  localparam int VALUE_WIDTH  = 16;

  localparam int OP_W    = 3;
  localparam int ROW_IW  = 8;
  localparam int COL_IW  = 10;
  localparam int OIDX_W  = 4;
  localparam int SCORE_W = 13;
  localparam int LR_W    = 12;
  localparam logic [LR_W-1:0] LR_RESET = 12'd1024;

  localparam int W1_DEPTH = HIDDEN_COUNT * INPUT_COUNT;
  localparam int W2_DEPTH = OUTPUT_COUNT * HIDDEN_COUNT;
  localparam int W1_AW = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
  localparam int W2_AW = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
  localparam int ADDR_W = (W1_AW > W2_AW) ? W1_AW : W2_AW;
  localparam int X_AW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int H_AW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int O_AW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;

  localparam int MAX_ROWS = (HIDDEN_COUNT > OUTPUT_COUNT) ? HIDDEN_COUNT : OUTPUT_COUNT;
  localparam int MAX_COLS_A = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
  localparam int MAX_COLS = (MAX_COLS_A > OUTPUT_COUNT) ? MAX_COLS_A : OUTPUT_COUNT;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // products of weight and operand fit 34 bits, plus growth over the longest row
  localparam int ACC_W = 34 + COL_W;
  localparam int SUM_W = ACC_W - 12;
  localparam int LD_W   = LR_W + 1 + VALUE_WIDTH;
  localparam int OPND_W = VALUE_WIDTH + 1;
  localparam int PROD_W = LD_W + OPND_W;

  typedef enum logic [OP_W-1:0] {
    OP_W1    = 3'd0,
    OP_W2    = 3'd1,
    OP_X     = 3'd2,
    OP_T     = 3'd3,
    OP_QUERY = 3'd4,
    OP_TRAIN = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_POST1, ST_POST2, ST_PREP1, ST_PREP2, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_L1, PH_L2, PH_DO, PH_HE, PH_U2, PH_U1
  } phase_e;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return VALUE_WIDTH'(hi);
    else if (v < lo) return VALUE_WIDTH'(lo);
    else return VALUE_WIDTH'(v);
  endfunction

  // piecewise linear sigmoid, signed q20.12 in, unsigned q1.12 out
  function automatic logic [SCORE_W-1:0] sigmoid_q12(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0] a;
    logic [SCORE_W-1:0] y;
    a = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    if (a >= SUM_W'(20480)) y = 13'd4096;
    else if (a >= SUM_W'(9728)) y = 13'(a >> 5) + 13'd3456;
    else if (a >= SUM_W'(4096)) y = 13'(a >> 3) + 13'd2560;
    else y = 13'(a >> 2) + 13'd2048;
    if (x[SUM_W-1]) y = 13'd4096 - y;
    return y;
  endfunction

endpackage

>>> sv/tsmt_in_if.sv
interface tsmt_in_if import tsmt_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic [ROW_IW-1:0]             row_index;
  logic [COL_IW-1:0]             column_index;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source(output valid, operation, row_index, column_index, value, input ready);
  modport sink(input valid, operation, row_index, column_index, value, output ready);
endinterface

>>> sv/tsmt_out_if.sv
interface tsmt_out_if import tsmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OIDX_W-1:0]  output_index;
  logic [SCORE_W-1:0] score;
  logic [OIDX_W-1:0]  best_index;
  logic               last;

  modport source(output valid, output_index, score, best_index, last, input ready);
  modport sink(input valid, output_index, score, best_index, last, output ready);
endinterface

>>> sv/tsmt_ram.sv
module tsmt_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/two_layer_sigmoid_mlp_trainer.sv
// Two-layer sigmoid perceptron with on-chip back-propagation, all values signed q4.12.
// Loads (first-layer weight, second-layer weight, input element, target element) are
// taken one word per cycle while idle. A query walks every weight once through a single
// multiply-accumulate pipeline fed by the weight memories, then emits one score word
// per output neuron, the last one carrying the argmax. A train command emits the same
// words and then computes the error terms and rewrites every weight in place. The rate
// is set by the one read port of each weight memory: one weight per cycle within a row,
// with the pipeline drained between rows. No word is taken while a query or train run
// is in progress. Memories are not cleared after reset.
module two_layer_sigmoid_mlp_trainer import tsmt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            learning_rate_we_i,
  input  logic [LR_W-1:0] learning_rate_i,
  tsmt_in_if.sink         in_i,
  tsmt_out_if.source      out_o
);

  // control state
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic                 train_q, train_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [LR_W-1:0]      lr_q;

  // datapath registers
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [LD_W-1:0]    ld_q, ld_d;
  logic signed [18:0]        p1_q, p1_d;
  logic signed [SUM_W+1:0]   m1_q, m1_d;
  logic [SCORE_W-1:0]        y_q [OUTPUT_COUNT];
  logic [SCORE_W-1:0]        y_d [OUTPUT_COUNT];
  logic signed [16:0]        e_q [OUTPUT_COUNT];
  logic signed [16:0]        e_d [OUTPUT_COUNT];
  logic signed [VALUE_WIDTH-1:0] dout_q [OUTPUT_COUNT];
  logic signed [VALUE_WIDTH-1:0] dout_d [OUTPUT_COUNT];
  logic signed [VALUE_WIDTH-1:0] t_q [OUTPUT_COUNT];
  logic [O_AW-1:0]           best_q, best_d;
  logic [SCORE_W-1:0]        bestv_q, bestv_d;

  // mac pipeline
  logic                      s1_vld_q, s2_vld_q;
  logic [COL_W-1:0]          s1_idx_q;
  logic [ADDR_W-1:0]         s1_addr_q, s2_addr_q;
  logic signed [VALUE_WIDTH-1:0] w2_q;
  logic signed [PROD_W-1:0]  prod_q;

  // output word register
  logic                 ov_q;
  logic [OIDX_W-1:0]    oidx_q;
  logic [SCORE_W-1:0]   oscore_q;
  logic [OIDX_W-1:0]    obest_q;
  logic                 olast_q;

  logic issue, adv, acc_clr, out_load, hid_we, herr_we;
  logic in_acc;
  logic row_last, col_last, is_dot, ri_last;
  logic [O_AW-1:0] ri;
  logic [H_AW-1:0] hi;

  // memory ports
  logic [VALUE_WIDTH-1:0] w1_rd, w2_rd, x_rd, hid_rd, herr_rd;
  logic                   w1_we, w2_we, x_we;
  logic [W1_AW-1:0]       w1_waddr;
  logic [W2_AW-1:0]       w2_waddr;
  logic [VALUE_WIDTH-1:0] w1_wd, w2_wd;
  logic [H_AW-1:0]        hid_raddr;
  logic [VALUE_WIDTH-1:0] hid_wd, herr_wd;

  // operand selection
  logic signed [VALUE_WIDTH-1:0] w_sel;
  logic signed [OPND_W-1:0]      a_sel;
  logic signed [LD_W-1:0]        m_left;
  logic signed [VALUE_WIDTH-1:0] w_new;
  logic signed [VALUE_WIDTH+7:0] w_sum;

  // post-row arithmetic
  logic signed [SUM_W-1:0]   sum;
  logic [SCORE_W-1:0]        sig;
  logic [SCORE_W-1:0]        ha;
  logic signed [16:0]        e_cur;
  logic signed [30:0]        ey;
  logic signed [32:0]        py;
  logic signed [SUM_W+13:0]  sa;
  logic signed [SUM_W+15:0]  mp;

  assign in_acc = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign ri = row_q[O_AW-1:0];
  assign hi = row_q[H_AW-1:0];
  assign is_dot = (phase_q == PH_L1) || (phase_q == PH_L2) || (phase_q == PH_HE);
  assign ri_last = (row_q == ROW_W'(OUTPUT_COUNT - 1));

  // row and column extents of each phase
  always_comb begin
    case (phase_q)
      PH_L1, PH_U1: begin
        row_last = (row_q == ROW_W'(HIDDEN_COUNT - 1));
        col_last = (col_q == COL_W'(INPUT_COUNT - 1));
      end
      PH_L2, PH_U2: begin
        row_last = ri_last;
        col_last = (col_q == COL_W'(HIDDEN_COUNT - 1));
      end
      PH_HE: begin
        row_last = (row_q == ROW_W'(HIDDEN_COUNT - 1));
        col_last = (col_q == COL_W'(OUTPUT_COUNT - 1));
      end
      default: begin
        row_last = ri_last;
        col_last = 1'b1;
      end
    endcase
  end

  // post-row arithmetic
  assign sum = SUM_W'(acc_q >>> 12);
  assign sig = sigmoid_q12(sum);
  assign ha  = hid_rd[SCORE_W-1:0];
  assign e_cur = 17'(t_q[ri]) - $signed({4'd0, y_q[ri]});
  assign ey = e_cur * $signed({1'b0, y_q[ri]});
  assign py = p1_q * $signed({1'b0, 13'd4096 - y_q[ri]});
  assign sa = sum * $signed({1'b0, ha});
  assign mp = m1_q * $signed({1'b0, 13'd4096 - ha});
  assign hid_wd  = VALUE_WIDTH'(sig);
  assign herr_wd = sat_val(64'(mp >>> 12));

  // sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    train_d = train_q;
    row_d   = row_q;
    col_d   = col_q;
    addr_d  = addr_q;
    ld_d    = ld_q;
    p1_d    = p1_q;
    m1_d    = m1_q;
    y_d     = y_q;
    e_d     = e_q;
    dout_d  = dout_q;
    best_d  = best_q;
    bestv_d = bestv_q;
    issue    = 1'b0;
    adv      = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    hid_we   = 1'b0;
    herr_we  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && ((in_i.operation == OP_QUERY) || (in_i.operation == OP_TRAIN))) begin
          train_d = (in_i.operation == OP_TRAIN);
          phase_d = PH_L1;
          row_d   = '0;
          col_d   = '0;
          addr_d  = '0;
          acc_clr = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        issue  = 1'b1;
        addr_d = (phase_q == PH_HE) ? addr_q + ADDR_W'(HIDDEN_COUNT) : addr_q + 1'b1;
        if (col_last) begin
          col_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          if (is_dot) state_d = ST_POST1;
          else adv = 1'b1;
        end
      end
      ST_POST1: begin
        case (phase_q)
          PH_L1: begin
            hid_we = 1'b1;
            adv    = 1'b1;
          end
          PH_L2: begin
            y_d[ri] = sig;
            // first index wins ties
            if ((row_q == '0) || (sig > bestv_q)) begin
              best_d  = ri;
              bestv_d = sig;
            end
            adv = 1'b1;
          end
          PH_DO: begin
            e_d[ri] = e_cur;
            p1_d    = 19'(ey >>> 12);
            state_d = ST_POST2;
          end
          PH_HE: begin
            m1_d    = (SUM_W+2)'(sa >>> 12);
            state_d = ST_POST2;
          end
          default: adv = 1'b1;
        endcase
      end
      ST_POST2: begin
        if (phase_q == PH_DO) begin
          dout_d[ri] = sat_val(64'(py >>> 12));
        end else begin
          herr_we = 1'b1;
        end
        adv = 1'b1;
      end
      ST_PREP1: begin
        state_d = ST_PREP2;
      end
      ST_PREP2: begin
        if (phase_q == PH_U2) ld_d = $signed({1'b0, lr_q}) * dout_q[ri];
        else ld_d = $signed({1'b0, lr_q}) * $signed(herr_rd);
        state_d = ST_RUN;
      end
      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          out_load = 1'b1;
          if (ri_last) begin
            row_d = '0;
            if (train_q) begin
              phase_d = PH_DO;
              state_d = ST_POST1;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // end of one row: next row or next phase
    if (adv) begin
      acc_clr = 1'b1;
      if (row_last) begin
        row_d  = '0;
        addr_d = '0;
        case (phase_q)
          PH_L1: begin
            phase_d = PH_L2;
            state_d = ST_RUN;
          end
          PH_L2: state_d = ST_EMIT;
          PH_DO: begin
            phase_d = PH_HE;
            state_d = ST_RUN;
          end
          PH_HE: begin
            phase_d = PH_U2;
            state_d = ST_PREP2;
          end
          PH_U2: begin
            phase_d = PH_U1;
            state_d = ST_PREP1;
          end
          default: state_d = ST_IDLE;
        endcase
      end else begin
        row_d = row_q + 1'b1;
        // column walk of the second-layer weights starts at the row itself
        if (phase_q == PH_HE) addr_d = ADDR_W'(row_q) + 1'b1;
        case (phase_q)
          PH_DO:   state_d = ST_POST1;
          PH_U2:   state_d = ST_PREP2;
          PH_U1:   state_d = ST_PREP1;
          default: state_d = ST_RUN;
        endcase
      end
    end
  end

  // stage one operands, memory data is valid here
  always_comb begin
    if ((phase_q == PH_L1) || (phase_q == PH_U1)) w_sel = $signed(w1_rd);
    else w_sel = $signed(w2_rd);
    case (phase_q)
      PH_L1, PH_U1: a_sel = OPND_W'($signed(x_rd));
      PH_HE:        a_sel = e_q[s1_idx_q[O_AW-1:0]];
      default:      a_sel = $signed({4'd0, ha});
    endcase
    m_left = is_dot ? LD_W'(w_sel) : ld_q;
  end

  // accumulate or rewrite in stage two
  always_comb begin
    acc_d = acc_q;
    if (acc_clr) acc_d = '0;
    else if (s2_vld_q && is_dot) acc_d = acc_q + ACC_W'(prod_q);
  end
  assign w_sum = (VALUE_WIDTH+8)'(w2_q) + (VALUE_WIDTH+8)'(prod_q >>> 24);
  assign w_new = sat_val(64'(w_sum));

  // weight write ports: loads when idle, in-place update during training
  always_comb begin
    w1_we    = 1'b0;
    w1_waddr = W1_AW'(32'(in_i.row_index) * INPUT_COUNT + 32'(in_i.column_index));
    w1_wd    = in_i.value;
    w2_we    = 1'b0;
    w2_waddr = W2_AW'(32'(in_i.row_index) * HIDDEN_COUNT + 32'(in_i.column_index));
    w2_wd    = in_i.value;
    x_we     = 1'b0;
    if (s2_vld_q && (phase_q == PH_U1)) begin
      w1_we    = 1'b1;
      w1_waddr = s2_addr_q[W1_AW-1:0];
      w1_wd    = w_new;
    end else if (in_acc && (in_i.operation == OP_W1) &&
                 (32'(in_i.row_index) < HIDDEN_COUNT) &&
                 (32'(in_i.column_index) < INPUT_COUNT)) begin
      w1_we = 1'b1;
    end
    if (s2_vld_q && (phase_q == PH_U2)) begin
      w2_we    = 1'b1;
      w2_waddr = s2_addr_q[W2_AW-1:0];
      w2_wd    = w_new;
    end else if (in_acc && (in_i.operation == OP_W2) &&
                 (32'(in_i.row_index) < OUTPUT_COUNT) &&
                 (32'(in_i.column_index) < HIDDEN_COUNT)) begin
      w2_we = 1'b1;
    end
    if (in_acc && (in_i.operation == OP_X) && (32'(in_i.column_index) < INPUT_COUNT)) begin
      x_we = 1'b1;
    end
  end

  assign hid_raddr = ((state_q == ST_RUN) && ((phase_q == PH_L2) || (phase_q == PH_U2)))
                   ? col_q[H_AW-1:0] : hi;

  tsmt_ram #(.Width(VALUE_WIDTH), .Depth(W1_DEPTH)) u_w1_ram (
    .clk_i  (clk_i),
    .we_i   (w1_we),
    .waddr_i(w1_waddr),
    .wdata_i(w1_wd),
    .raddr_i(addr_q[W1_AW-1:0]),
    .rdata_o(w1_rd)
  );

  tsmt_ram #(.Width(VALUE_WIDTH), .Depth(W2_DEPTH)) u_w2_ram (
    .clk_i  (clk_i),
    .we_i   (w2_we),
    .waddr_i(w2_waddr),
    .wdata_i(w2_wd),
    .raddr_i(addr_q[W2_AW-1:0]),
    .rdata_o(w2_rd)
  );

  tsmt_ram #(.Width(VALUE_WIDTH), .Depth(INPUT_COUNT)) u_x_ram (
    .clk_i  (clk_i),
    .we_i   (x_we),
    .waddr_i(in_i.column_index[X_AW-1:0]),
    .wdata_i(in_i.value),
    .raddr_i(col_q[X_AW-1:0]),
    .rdata_o(x_rd)
  );

  tsmt_ram #(.Width(VALUE_WIDTH), .Depth(HIDDEN_COUNT)) u_hid_ram (
    .clk_i  (clk_i),
    .we_i   (hid_we),
    .waddr_i(hi),
    .wdata_i(hid_wd),
    .raddr_i(hid_raddr),
    .rdata_o(hid_rd)
  );

  tsmt_ram #(.Width(VALUE_WIDTH), .Depth(HIDDEN_COUNT)) u_herr_ram (
    .clk_i  (clk_i),
    .we_i   (herr_we),
    .waddr_i(hi),
    .wdata_i(herr_wd),
    .raddr_i(hi),
    .rdata_o(herr_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_L1;
      train_q  <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      addr_q   <= '0;
      lr_q     <= LR_RESET;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      train_q  <= train_d;
      row_q    <= row_d;
      col_q    <= col_d;
      addr_q   <= addr_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (learning_rate_we_i) lr_q <= learning_rate_i;
      if (out_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    ld_q      <= ld_d;
    p1_q      <= p1_d;
    m1_q      <= m1_d;
    y_q       <= y_d;
    e_q       <= e_d;
    dout_q    <= dout_d;
    best_q    <= best_d;
    bestv_q   <= bestv_d;
    s1_idx_q  <= col_q;
    s1_addr_q <= addr_q;
    s2_addr_q <= s1_addr_q;
    w2_q      <= w_sel;
    prod_q    <= m_left * a_sel;
    if (in_acc && (in_i.operation == OP_T) && (32'(in_i.row_index) < OUTPUT_COUNT)) begin
      t_q[in_i.row_index[O_AW-1:0]] <= in_i.value;
    end
    if (out_load) begin
      oidx_q   <= OIDX_W'(row_q);
      oscore_q <= y_q[ri];
      obest_q  <= ri_last ? OIDX_W'(best_q) : '0;
      olast_q  <= ri_last;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.output_index = oidx_q;
  assign out_o.score        = oscore_q;
  assign out_o.best_index   = obest_q;
  assign out_o.last         = olast_q;

`ifndef SYNTHESIS
  // no word is taken while the mac pipeline holds work
  a_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!s1_vld_q && !s2_vld_q))
    else $error("input taken while pipeline busy");

  // the marked final word belongs to the last output neuron
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.output_index == OIDX_W'(OUTPUT_COUNT - 1)))
    else $error("last word on wrong neuron");

  // an output word is loaded only into a free or draining register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!ov_q || out_o.ready))
    else $error("output word overwritten");
`endif

endmodule
